/* rtl/core/pdr_pkg.sv */
// Shared types and constants for the protecting-distance replacement block.
// Used by the channel interfaces, the controller, the datapath and the top level.
// No dependencies.
package pdr_pkg;

  // Fixed field widths of the channels and the configuration port.
  localparam int ADDR_W      = 48;
  localparam int WAY_FIELD_W = 4;
  localparam int ACC_W       = 2;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 8;
  localparam int WAYS_CFG_W  = 5;
  localparam int PD_CFG_W    = 8;

  // Default geometry handed down from the top level.
  localparam int WAYS_DEF        = 16;
  localparam int SET_BITS_DEF    = 6;
  localparam int OFFSET_BITS_DEF = 6;
  localparam int ADDR_BITS_DEF   = 48;
  localparam int DIST_BITS_DEF   = 8;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_WAYS_IN_USE     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WRITE_BACK_MODE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PROTECT_DIST    = 2'd2;

  // Configuration reset values.
  localparam logic [WAYS_CFG_W-1:0] WAYS_IN_USE_RST = 5'd16;
  localparam logic                  WB_MODE_RST     = 1'b1;
  localparam logic [PD_CFG_W-1:0]   PROTECT_DIST_RST = 8'd16;

  // Item kinds and access types.
  localparam logic             KIND_HIT   = 1'b0;
  localparam logic             KIND_FILL  = 1'b1;
  localparam logic [ACC_W-1:0] ACC_READ     = 2'd0;
  localparam logic [ACC_W-1:0] ACC_WRITE    = 2'd1;
  localparam logic [ACC_W-1:0] ACC_PREFETCH = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clear;   // write one cleared set of line state
    logic load;    // capture the accepted beat and read its set
    logic commit;  // write the updated set back and load any result
  } pdr_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clear_last;   // the clearing pass is on its last set
    logic is_fill;      // the item under evaluation is a fill
    logic out_blocked;  // the output register holds a beat that is not taken
  } pdr_stat_t;

endpackage

/* rtl/core/pdr_if.sv */
// Valid/ready channel interfaces for requests and victim results.
// Depends on pdr_pkg for the field widths.
interface pdr_req_if;
  logic                             valid;
  logic                             ready;
  logic                             kind;
  logic [pdr_pkg::ADDR_W-1:0]       address;
  logic [pdr_pkg::WAY_FIELD_W-1:0]  hit_way;
  logic [pdr_pkg::ACC_W-1:0]        access_type;

  modport source (output valid, kind, address, hit_way, access_type, input ready);
  modport sink (input valid, kind, address, hit_way, access_type, output ready);
endinterface

interface pdr_rsp_if;
  logic                             valid;
  logic                             ready;
  logic [pdr_pkg::WAY_FIELD_W-1:0]  victim_way;
  logic                             victim_was_valid;
  logic [pdr_pkg::ADDR_W-1:0]       evicted_address;
  logic                             writeback;

  modport source (output valid, victim_way, victim_was_valid, evicted_address, writeback,
                  input ready);
  modport sink (input valid, victim_way, victim_was_valid, evicted_address, writeback,
                output ready);
endinterface

/* rtl/core/protecting_distance_replacement_top.sv */
// Top level of the protecting-distance replacement block.
// Depends on pdr_pkg, pdr_if, pdr_ctrl and pdr_datapath.
//
// Usage:
// - req carries one beat per cache access: kind (hit or fill), byte address,
//   hit_way for hits and access_type for fills.
// - rsp carries one beat per fill: victim way, whether it held a valid line,
//   the evicted line address and the writeback flag. Hits give no beat.
// - The configuration port writes ways_in_use, write_back_mode and protect_distance
//   by index; no read-back. The user writes only while the block is idle (unenforced).
// Timing:
// - After reset, line state is cleared one set per cycle across all 2**SET_BITS
//   sets (64 by default), with req.ready low; configuration writes are taken.
// - An item is accepted in S_IDLE, which reads its set; S_EVAL then picks the
//   victim and writes the set back. A new item is accepted only after the
//   previous one has been written back.
// - A fill's result is registered in the output register when its evaluation
//   commits. While that register holds a beat not yet taken, the next
//   fill waits in evaluation; hits go on regardless.
module protecting_distance_replacement_top #(
  parameter int WAYS        = pdr_pkg::WAYS_DEF,
  parameter int SET_BITS    = pdr_pkg::SET_BITS_DEF,
  parameter int OFFSET_BITS = pdr_pkg::OFFSET_BITS_DEF,
  parameter int ADDR_BITS   = pdr_pkg::ADDR_BITS_DEF,
  parameter int DIST_BITS   = pdr_pkg::DIST_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  pdr_req_if.sink                        req,
  pdr_rsp_if.source                      rsp,
  input  logic                           cfg_we,
  input  logic [pdr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pdr_pkg::CFG_DATA_W-1:0] cfg_data
);

  pdr_pkg::pdr_cmd_t  cmd;
  pdr_pkg::pdr_stat_t stat;

  // Controller.
  pdr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  // Datapath.
  pdr_datapath #(
    .WAYS        (WAYS),
    .SET_BITS    (SET_BITS),
    .OFFSET_BITS (OFFSET_BITS),
    .ADDR_BITS   (ADDR_BITS),
    .DIST_BITS   (DIST_BITS)
  ) u_datapath (
    .clk                  (clk),
    .rst                  (rst),
    .cmd                  (cmd),
    .stat                 (stat),
    .in_kind              (req.kind),
    .in_address           (req.address),
    .in_hit_way           (req.hit_way),
    .in_access_type       (req.access_type),
    .cfg_we               (cfg_we),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data),
    .out_valid            (rsp.valid),
    .out_ready            (rsp.ready),
    .out_victim_way       (rsp.victim_way),
    .out_victim_was_valid (rsp.victim_was_valid),
    .out_evicted_address  (rsp.evicted_address),
    .out_writeback        (rsp.writeback)
  );

endmodule

/* rtl/core/pdr_ctrl.sv */
// Controller state machine: clearing pass after reset, accept, evaluate and write back.
// Depends on pdr_pkg for the command and status structs.
module pdr_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_ready,
  output pdr_pkg::pdr_cmd_t  cmd,
  input  pdr_pkg::pdr_stat_t stat
);

  typedef enum logic [2:0] {
    S_CLEAR = 3'b001,
    S_IDLE  = 3'b010,
    S_EVAL  = 3'b100
  } state_t;

  state_t state;
  state_t state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands.
  always_comb begin
    state_next = state;
    req_ready  = 1'b0;
    cmd        = '0;
    unique case (state)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (stat.clear_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.load   = 1'b1;
          state_next = S_EVAL;
        end
      end
      S_EVAL: begin
        // A fill waits here while the previous result has not been taken.
        if (!(stat.is_fill && stat.out_blocked)) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

endmodule

/* rtl/core/pdr_datapath.sv */
// Datapath: configuration registers, per-set line state memories, victim search,
// set update and the result register. Depends on pdr_pkg.
module pdr_datapath #(
  parameter int WAYS        = pdr_pkg::WAYS_DEF,
  parameter int SET_BITS    = pdr_pkg::SET_BITS_DEF,
  parameter int OFFSET_BITS = pdr_pkg::OFFSET_BITS_DEF,
  parameter int ADDR_BITS   = pdr_pkg::ADDR_BITS_DEF,
  parameter int DIST_BITS   = pdr_pkg::DIST_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  pdr_pkg::pdr_cmd_t                  cmd,
  output pdr_pkg::pdr_stat_t                 stat,
  input  logic                               in_kind,
  input  logic [pdr_pkg::ADDR_W-1:0]         in_address,
  input  logic [pdr_pkg::WAY_FIELD_W-1:0]    in_hit_way,
  input  logic [pdr_pkg::ACC_W-1:0]          in_access_type,
  input  logic                               cfg_we,
  input  logic [pdr_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [pdr_pkg::CFG_DATA_W-1:0]     cfg_data,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [pdr_pkg::WAY_FIELD_W-1:0]    out_victim_way,
  output logic                               out_victim_was_valid,
  output logic [pdr_pkg::ADDR_W-1:0]         out_evicted_address,
  output logic                               out_writeback
);

  localparam int NSETS    = 1 << SET_BITS;
  localparam int SET_W    = (SET_BITS > 0) ? SET_BITS : 1;
  localparam int TAG_BITS = ADDR_BITS - SET_BITS - OFFSET_BITS;
  localparam int LSB      = SET_BITS + OFFSET_BITS;
  localparam int WAY_W    = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int LVLS     = $clog2(WAYS);
  localparam int PAD      = 1 << LVLS;
  localparam int CNT_W    = $clog2(WAYS + 1);
  localparam int DIST_MAX = (1 << DIST_BITS) - 1;
  localparam logic [SET_W-1:0]     LAST_SET = SET_W'(NSETS - 1);
  localparam logic [ADDR_BITS-1:0] SET_MASK = ADDR_BITS'(NSETS - 1);

  // Configuration registers.
  logic [pdr_pkg::WAYS_CFG_W-1:0] ways_in_use;
  logic                           write_back_mode;
  logic [pdr_pkg::PD_CFG_W-1:0]   protect_distance;

  always_ff @(posedge clk) begin
    if (rst) begin
      ways_in_use      <= pdr_pkg::WAYS_IN_USE_RST;
      write_back_mode  <= pdr_pkg::WB_MODE_RST;
      protect_distance <= pdr_pkg::PROTECT_DIST_RST;
    end else if (cfg_we) begin
      if (cfg_index == pdr_pkg::REG_WAYS_IN_USE) begin
        ways_in_use <= cfg_data[pdr_pkg::WAYS_CFG_W-1:0];
      end
      if (cfg_index == pdr_pkg::REG_WRITE_BACK_MODE) begin
        write_back_mode <= cfg_data[0];
      end
      if (cfg_index == pdr_pkg::REG_PROTECT_DIST) begin
        protect_distance <= cfg_data[pdr_pkg::PD_CFG_W-1:0];
      end
    end
  end

  // Active way count and the distance loaded on a hit or fill.
  logic [CNT_W-1:0]     n_eff;
  logic [DIST_BITS-1:0] load_dist;

  always_comb begin
    if (ways_in_use == '0) begin
      n_eff = CNT_W'(1);
    end else if (int'(ways_in_use) > WAYS) begin
      n_eff = CNT_W'(WAYS);
    end else begin
      n_eff = CNT_W'(ways_in_use);
    end
    if (int'(protect_distance) > DIST_MAX) begin
      load_dist = DIST_BITS'(DIST_MAX);
    end else begin
      load_dist = DIST_BITS'(protect_distance);
    end
  end

  // Split the incoming address into set and tag.
  logic [ADDR_BITS-1:0] addr_in;
  logic [SET_W-1:0]     set_in;
  logic [TAG_BITS-1:0]  tag_in;

  assign addr_in = ADDR_BITS'(in_address);
  assign set_in  = SET_W'((addr_in >> OFFSET_BITS) & SET_MASK);
  assign tag_in  = TAG_BITS'(addr_in >> LSB);

  // Captured item.
  logic                          kind_q;
  logic [SET_W-1:0]              set_q;
  logic [TAG_BITS-1:0]           tag_new_q;
  logic [pdr_pkg::WAY_FIELD_W-1:0] hit_way_q;
  logic [pdr_pkg::ACC_W-1:0]     acc_q;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_q    <= in_kind;
      set_q     <= set_in;
      tag_new_q <= tag_in;
      hit_way_q <= in_hit_way;
      acc_q     <= in_access_type;
    end
  end

  // Clearing pass counter.
  logic [SET_W-1:0] clr_idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_idx <= '0;
    end else if (cmd.clear) begin
      clr_idx <= clr_idx + SET_W'(1);
    end
  end

  // Line state memories, one row per set, with registered read data.
  logic [WAYS-1:0]           vld_mem [NSETS];
  logic [WAYS-1:0]           drt_mem [NSETS];
  logic [WAYS-1:0]           rus_mem [NSETS];
  logic [WAYS*DIST_BITS-1:0] dst_mem [NSETS];
  logic [WAYS*TAG_BITS-1:0]  tag_mem [NSETS];

  logic [WAYS-1:0]           vld_q, drt_q, rus_q;
  logic [WAYS*DIST_BITS-1:0] dst_q;
  logic [WAYS*TAG_BITS-1:0]  tag_q;

  logic [WAYS-1:0]           vld_d, drt_d, rus_d;
  logic [WAYS*DIST_BITS-1:0] dst_d;
  logic [WAYS*TAG_BITS-1:0]  tag_d;
  logic                      meta_we;
  logic                      tag_we;
  logic [SET_W-1:0]          wr_set;

  assign meta_we = cmd.clear | cmd.commit;
  assign tag_we  = cmd.commit & (kind_q == pdr_pkg::KIND_FILL);
  assign wr_set  = cmd.clear ? clr_idx : set_q;

  always_ff @(posedge clk) begin
    if (meta_we) begin
      vld_mem[wr_set] <= cmd.clear ? '0 : vld_d;
      drt_mem[wr_set] <= cmd.clear ? '0 : drt_d;
      rus_mem[wr_set] <= cmd.clear ? '0 : rus_d;
      dst_mem[wr_set] <= cmd.clear ? '0 : dst_d;
    end
    if (tag_we) begin
      tag_mem[set_q] <= tag_d;
    end
    if (cmd.load) begin
      vld_q <= vld_mem[set_in];
      drt_q <= drt_mem[set_in];
      rus_q <= rus_mem[set_in];
      dst_q <= dst_mem[set_in];
      tag_q <= tag_mem[set_in];
    end
  end

  // Per-way views of the set under evaluation.
  logic [DIST_BITS-1:0] dist_w [WAYS];
  logic [WAYS-1:0]      way_on;
  logic [WAYS-1:0]      cand;
  logic [WAYS-1:0]      zero_w;

  always_comb begin
    for (int j = 0; j < WAYS; j++) begin
      dist_w[j] = dst_q[j*DIST_BITS +: DIST_BITS];
      way_on[j] = (j < int'(n_eff));
      zero_w[j] = way_on[j] && (dist_w[j] == '0);
    end
    // Unreused ways compete first; if all are reused, every active way does.
    if ((way_on & ~rus_q) != '0) begin
      cand = way_on & ~rus_q;
    end else begin
      cand = way_on;
    end
  end

  // First invalid way and first zero-distance way.
  logic [WAY_W-1:0] inv_idx, zero_idx;
  logic             any_inv, any_zero;

  always_comb begin
    inv_idx  = '0;
    zero_idx = '0;
    for (int j = WAYS - 1; j >= 0; j--) begin
      if (way_on[j] && !vld_q[j]) begin
        inv_idx = WAY_W'(j);
      end
      if (zero_w[j]) begin
        zero_idx = WAY_W'(j);
      end
    end
    any_inv  = (way_on & ~vld_q) != '0;
    any_zero = zero_w != '0;
  end

  // Largest-distance tree; the left (earlier) side wins a tie.
  logic [DIST_BITS-1:0] t_d [LVLS+1][PAD];
  logic                 t_v [LVLS+1][PAD];
  logic [WAY_W-1:0]     t_i [LVLS+1][PAD];

  for (genvar p = 0; p < PAD; p++) begin : g_leaf
    if (p < WAYS) begin : g_real
      assign t_v[0][p] = cand[p];
      assign t_d[0][p] = dist_w[p];
      assign t_i[0][p] = WAY_W'(p);
    end else begin : g_pad
      assign t_v[0][p] = 1'b0;
      assign t_d[0][p] = '0;
      assign t_i[0][p] = '0;
    end
  end

  for (genvar l = 0; l < LVLS; l++) begin : g_lvl
    for (genvar p = 0; p < (PAD >> (l + 1)); p++) begin : g_node
      logic take_r;
      assign take_r = t_v[l][2*p+1] &&
                      (!t_v[l][2*p] || (t_d[l][2*p+1] > t_d[l][2*p]));
      assign t_v[l+1][p] = t_v[l][2*p] | t_v[l][2*p+1];
      assign t_d[l+1][p] = take_r ? t_d[l][2*p+1] : t_d[l][2*p];
      assign t_i[l+1][p] = take_r ? t_i[l][2*p+1] : t_i[l][2*p];
    end
  end

  // Victim selection in priority order.
  logic [WAY_W-1:0] vic;

  always_comb begin
    priority if (any_inv) begin
      vic = inv_idx;
    end else if (any_zero) begin
      vic = zero_idx;
    end else begin
      vic = t_i[LVLS][0];
    end
  end

  // Updated set: install or in-range hit, then age every active nonzero distance.
  logic hit_ok;
  logic is_fill;

  assign is_fill = (kind_q == pdr_pkg::KIND_FILL);
  assign hit_ok  = int'(hit_way_q) < int'(n_eff);

  always_comb begin
    logic [DIST_BITS-1:0] d;
    logic                 sel;
    vld_d = vld_q;
    drt_d = drt_q;
    rus_d = rus_q;
    dst_d = dst_q;
    tag_d = tag_q;
    for (int j = 0; j < WAYS; j++) begin
      d   = dist_w[j];
      sel = is_fill ? (int'(vic) == j) : (hit_ok && (int'(hit_way_q) == j));
      if (sel) begin
        d = load_dist;
        if (is_fill) begin
          vld_d[j] = 1'b1;
          rus_d[j] = 1'b0;
          drt_d[j] = (acc_q == pdr_pkg::ACC_WRITE);
        end else begin
          rus_d[j] = 1'b1;
        end
      end
      if (way_on[j] && (d != '0) && (is_fill || hit_ok)) begin
        d = d - DIST_BITS'(1);
      end
      dst_d[j*DIST_BITS +: DIST_BITS] = d;
    end
    tag_d[int'(vic)*TAG_BITS +: TAG_BITS] = tag_new_q;
  end

  // Result fields of the victim.
  logic                 was_valid;
  logic [TAG_BITS-1:0]  old_tag;
  logic [ADDR_BITS-1:0] evicted;

  assign was_valid = vld_q[vic];
  assign old_tag   = tag_q[int'(vic)*TAG_BITS +: TAG_BITS];
  assign evicted   = was_valid ?
                     ((ADDR_BITS'(old_tag) << LSB) |
                      ((ADDR_BITS'(set_q) & SET_MASK) << OFFSET_BITS)) : '0;

  // Output register; a new beat may replace one taken in the same cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit && is_fill) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && is_fill) begin
      out_victim_way       <= pdr_pkg::WAY_FIELD_W'(vic);
      out_victim_was_valid <= was_valid;
      out_evicted_address  <= pdr_pkg::ADDR_W'(evicted);
      out_writeback        <= was_valid & drt_q[vic] & write_back_mode;
    end
  end

  // Status to the controller.
  assign stat.clear_last  = (clr_idx == LAST_SET);
  assign stat.is_fill     = is_fill;
  assign stat.out_blocked = out_valid & ~out_ready;

endmodule

/* verif/tb_protecting_distance_replacement_top.sv */
// Self-checking testbench for the protecting-distance replacement block.
// Depends on pdr_pkg, the pdr_req_if/pdr_rsp_if channel interfaces and the RTL top level.
// Victim choices are predicted from a shadow copy of the per-line state.
`timescale 1ns / 1ps

module tb_protecting_distance_replacement_top;
  import pdr_pkg::*;

  localparam int SET_W     = SET_BITS_DEF;
  localparam int OFF_W     = OFFSET_BITS_DEF;
  localparam int TAG_W     = ADDR_W - SET_W - OFF_W;
  localparam int NUM_SETS  = 1 << SET_W;
  localparam int NUM_WAYS  = WAYS_DEF;
  localparam int ROWS      = 18;
  localparam int PHASE_LEN = 195;
  localparam int LIMIT     = 400000;
  localparam logic [ACC_W-1:0] ACC_OTHER = 2'd3;

  typedef struct packed {
    logic [WAY_FIELD_W-1:0] way;
    logic                   was_valid;
    logic [ADDR_W-1:0]      evicted;
    logic                   writeback;
  } victim_t;

  typedef struct packed {
    logic                   kind;
    logic [ADDR_W-1:0]      addr;
    logic [WAY_FIELD_W-1:0] way;
    logic [ACC_W-1:0]       acc;
    logic                   typed;
    victim_t                res;
  } access_row_t;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // Hand-written expectation travelling alongside the request beat.
  logic    drv_typed;
  victim_t drv_typed_res;

  pdr_req_if req_bus ();
  pdr_rsp_if rsp_bus ();

  protecting_distance_replacement_top dut (
    .clk       (clk),
    .rst       (rst),
    .req       (req_bus),
    .rsp       (rsp_bus),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Shadow line state and configuration.
  logic             line_valid_q  [NUM_SETS][NUM_WAYS];
  logic [TAG_W-1:0] line_tag_q    [NUM_SETS][NUM_WAYS];
  logic             line_dirty_q  [NUM_SETS][NUM_WAYS];
  logic             line_reused_q [NUM_SETS][NUM_WAYS];
  logic [7:0]       line_dist_q   [NUM_SETS][NUM_WAYS];
  logic [WAYS_CFG_W-1:0] ways_cfg;
  logic                  wb_cfg;
  logic [PD_CFG_W-1:0]   pd_cfg;

  victim_t     pending_victims[$];
  victim_t     want;
  access_row_t directed_rows[ROWS];

  int errors;
  int cycle_count;
  int fills_seen, valid_evictions, writebacks_seen, hits_applied, hits_ignored;
  int calm_items;
  bit steady;
  bit long_hold_req;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  function automatic int active_ways(input logic [WAYS_CFG_W-1:0] w);
    if (w == 0) return 1;
    if (w > NUM_WAYS) return NUM_WAYS;
    return int'(w);
  endfunction

  function automatic logic [ADDR_W-1:0] make_addr(input logic [TAG_W-1:0] tag,
                                                  input int set_i, input int off);
    return {tag, set_i[SET_W-1:0], off[OFF_W-1:0]};
  endfunction

  function automatic access_row_t make_row(input logic kind, input logic [ADDR_W-1:0] addr,
                                           input int way, input logic [ACC_W-1:0] acc,
                                           input logic typed, input int res_way,
                                           input logic res_valid);
    access_row_t r;
    r.kind = kind;
    r.addr = addr;
    r.way = way[WAY_FIELD_W-1:0];
    r.acc = acc;
    r.typed = typed;
    r.res.way = res_way[WAY_FIELD_W-1:0];
    r.res.was_valid = res_valid;
    r.res.evicted = '0;
    r.res.writeback = 1'b0;
    return r;
  endfunction

  // Victim order: first invalid way, then first zero distance, then the
  // earliest largest distance among unreused ways, then among all ways.
  function automatic int choose_victim(input int s, input int n);
    int best;
    logic [7:0] maxd;
    bit found;
    best = 0;
    maxd = '0;
    found = 0;
    for (int j = 0; j < n; j++)
      if (!line_valid_q[s][j]) return j;
    for (int j = 0; j < n; j++)
      if (line_dist_q[s][j] == 0) return j;
    for (int j = 0; j < n; j++) begin
      if (!line_reused_q[s][j] && (!found || line_dist_q[s][j] > maxd)) begin
        found = 1;
        maxd = line_dist_q[s][j];
        best = j;
      end
    end
    if (found) return best;
    for (int j = 0; j < n; j++) begin
      if (j == 0 || line_dist_q[s][j] > maxd) begin
        maxd = line_dist_q[s][j];
        best = j;
      end
    end
    return best;
  endfunction

  task automatic age_set(input int s, input int n);
    for (int j = 0; j < n; j++)
      if (line_dist_q[s][j] != 0) line_dist_q[s][j] = line_dist_q[s][j] - 8'd1;
  endtask

  // Apply one accepted request beat to the shadow state; a fill queues its victim.
  task automatic predict_access(input logic kind, input logic [ADDR_W-1:0] addr,
                                input logic [WAY_FIELD_W-1:0] hway,
                                input logic [ACC_W-1:0] acc,
                                input logic typed, input victim_t typed_res);
    int s, n, v;
    logic [TAG_W-1:0] tag;
    victim_t res;
    s = int'(addr[OFF_W +: SET_W]);
    tag = addr[ADDR_W-1 -: TAG_W];
    n = active_ways(ways_cfg);
    if (kind == KIND_HIT) begin
      if (int'(hway) < n) begin
        hits_applied++;
        line_reused_q[s][hway] = 1'b1;
        line_dist_q[s][hway] = pd_cfg;
        age_set(s, n);
      end else begin
        hits_ignored++;
      end
    end else begin
      v = choose_victim(s, n);
      res.way = v[WAY_FIELD_W-1:0];
      res.was_valid = line_valid_q[s][v];
      res.evicted = '0;
      res.writeback = 1'b0;
      if (line_valid_q[s][v]) begin
        res.evicted = {line_tag_q[s][v], s[SET_W-1:0], {OFF_W{1'b0}}};
        res.writeback = line_dirty_q[s][v] && wb_cfg;
      end
      line_valid_q[s][v] = 1'b1;
      line_tag_q[s][v] = tag;
      line_reused_q[s][v] = 1'b0;
      line_dist_q[s][v] = pd_cfg;
      line_dirty_q[s][v] = (acc == ACC_WRITE);
      age_set(s, n);
      pending_victims.push_back(typed ? typed_res : res);
    end
  endtask

  task automatic compare_field(input string name, input logic [ADDR_W-1:0] exp_v,
                               input logic [ADDR_W-1:0] got_v);
    if (exp_v !== got_v) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_v, got_v);
    end
  endtask

  // Sample both channels and the register port at the rising edge.
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_we) begin
        case (cfg_index)
          REG_WAYS_IN_USE:     ways_cfg = cfg_data[WAYS_CFG_W-1:0];
          REG_WRITE_BACK_MODE: wb_cfg = cfg_data[0];
          REG_PROTECT_DIST:    pd_cfg = cfg_data[PD_CFG_W-1:0];
          default: ;
        endcase
      end
      if (rsp_bus.valid && rsp_bus.ready) begin
        if (pending_victims.size() == 0) begin
          errors++;
          $display("%0t: result beat with nothing expected, expected none, got way %0d",
                   $time, rsp_bus.victim_way);
        end else begin
          want = pending_victims.pop_front();
          fills_seen++;
          if (rsp_bus.victim_was_valid) valid_evictions++;
          if (rsp_bus.writeback) writebacks_seen++;
          compare_field("victim_way", want.way, rsp_bus.victim_way);
          compare_field("victim_was_valid", want.was_valid, rsp_bus.victim_was_valid);
          compare_field("evicted_address", want.evicted, rsp_bus.evicted_address);
          compare_field("writeback", want.writeback, rsp_bus.writeback);
        end
      end
      if (req_bus.valid && req_bus.ready)
        predict_access(req_bus.kind, req_bus.address, req_bus.hit_way,
                       req_bus.access_type, drv_typed, drv_typed_res);
    end
  end

  // Result side: random stall bursts, one long hold-off on request, none at the end.
  initial begin
    int stall_left, calm_left, hold_left;
    stall_left = 0;
    calm_left = 0;
    hold_left = 0;
    rsp_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold_req) begin
        long_hold_req = 0;
        hold_left = 300;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_bus.ready <= 1'b0;
      end else if (steady) begin
        rsp_bus.ready <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        rsp_bus.ready <= 1'b0;
      end else if (calm_left > 0) begin
        calm_left--;
        rsp_bus.ready <= 1'b1;
      end else if ($urandom_range(0, 1) == 1) begin
        stall_left = $urandom_range(1, 17) - 1;
        rsp_bus.ready <= 1'b0;
      end else begin
        calm_left = $urandom_range(1, 60);
        rsp_bus.ready <= 1'b1;
      end
    end
  end

  task automatic push_access(input logic kind, input logic [ADDR_W-1:0] addr,
                             input logic [WAY_FIELD_W-1:0] way,
                             input logic [ACC_W-1:0] acc,
                             input logic typed, input victim_t typed_res);
    @(negedge clk);
    req_bus.valid <= 1'b1;
    req_bus.kind <= kind;
    req_bus.address <= addr;
    req_bus.hit_way <= way;
    req_bus.access_type <= acc;
    drv_typed <= typed;
    drv_typed_res <= typed_res;
    do @(posedge clk); while (!req_bus.ready);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value[CFG_DATA_W-1:0];
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Drain: every victim back, then room for a trailing hit to finish.
  task automatic drain;
    @(negedge clk);
    req_bus.valid <= 1'b0;
    while (pending_victims.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  // One register setting followed by random accesses, mostly to two busy sets.
  task automatic run_phase(input int ways, input int wb, input int pd, input int hot,
                           input bit hold_off);
    int eff, set_i;
    logic [63:0] r;
    logic kind;
    logic [WAY_FIELD_W-1:0] way;
    victim_t none;
    none = '0;
    drain();
    write_reg(REG_WAYS_IN_USE, ways);
    write_reg(REG_WRITE_BACK_MODE, wb);
    write_reg(REG_PROTECT_DIST, pd);
    if (hold_off) long_hold_req = 1;
    eff = active_ways(ways[WAYS_CFG_W-1:0]);
    for (int i = 0; i < PHASE_LEN; i++) begin
      if (!steady) begin
        if (calm_items > 0) begin
          calm_items--;
        end else if ($urandom_range(0, 1) == 1) begin
          repeat ($urandom_range(1, 17)) begin
            @(negedge clk);
            req_bus.valid <= 1'b0;
          end
        end else begin
          calm_items = $urandom_range(1, 30);
        end
      end
      r = {$urandom(), $urandom()};
      set_i = ($urandom_range(0, 99) < 85) ? hot + $urandom_range(0, 1)
                                            : $urandom_range(0, NUM_SETS - 1);
      kind = ($urandom_range(0, 1) == 1) ? KIND_FILL : KIND_HIT;
      if ($urandom_range(0, 9) != 0) way = $urandom_range(0, eff - 1);
      else way = $urandom_range(0, NUM_WAYS - 1);
      push_access(kind, make_addr(r[TAG_W-1:0], set_i, int'(r[63:58])), way,
                  $urandom_range(0, 3), 1'b0, none);
    end
  endtask

  // Stimulus sequence and final verdict.
  initial begin
    logic [TAG_W-1:0] ones;
    ones = '1;
    errors = 0;
    cycle_count = 0;
    fills_seen = 0;
    valid_evictions = 0;
    writebacks_seen = 0;
    hits_applied = 0;
    hits_ignored = 0;
    calm_items = 0;
    steady = 0;
    long_hold_req = 0;
    ways_cfg = WAYS_IN_USE_RST;
    wb_cfg = WB_MODE_RST;
    pd_cfg = PROTECT_DIST_RST;
    for (int s = 0; s < NUM_SETS; s++) begin
      for (int w = 0; w < NUM_WAYS; w++) begin
        line_valid_q[s][w] = 1'b0;
        line_tag_q[s][w] = '0;
        line_dirty_q[s][w] = 1'b0;
        line_reused_q[s][w] = 1'b0;
        line_dist_q[s][w] = '0;
      end
    end
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    req_bus.valid = 1'b0;
    req_bus.kind = KIND_HIT;
    req_bus.address = '0;
    req_bus.hit_way = '0;
    req_bus.access_type = ACC_READ;
    drv_typed = 1'b0;
    drv_typed_res = '0;

    // Directed accesses: two ways with a long distance, so the unreused and
    // all-reused choices both come up, plus ignored hits, a hit on an empty
    // line, the spare access type and the address extremes.
    directed_rows[0]  = make_row(KIND_FILL, make_addr('0, 0, 0), 0, ACC_WRITE, 1, 0, 0);
    directed_rows[1]  = make_row(KIND_FILL, make_addr(ones, 0, 63), 0, ACC_READ, 1, 1, 0);
    directed_rows[2]  = make_row(KIND_FILL, make_addr(5, 0, 17), 0, ACC_PREFETCH, 0, 0, 0);
    directed_rows[3]  = make_row(KIND_HIT, make_addr(7, 0, 0), 0, ACC_READ, 0, 0, 0);
    directed_rows[4]  = make_row(KIND_HIT, make_addr(9, 0, 33), 1, ACC_READ, 0, 0, 0);
    directed_rows[5]  = make_row(KIND_FILL, make_addr(6, 0, 1), 0, ACC_WRITE, 0, 0, 0);
    directed_rows[6]  = make_row(KIND_FILL, make_addr(7, 0, 2), 0, ACC_OTHER, 0, 0, 0);
    directed_rows[7]  = make_row(KIND_HIT, make_addr(8, 0, 0), 2, ACC_READ, 0, 0, 0);
    directed_rows[8]  = make_row(KIND_HIT, make_addr(8, 0, 0), 15, ACC_READ, 0, 0, 0);
    directed_rows[9]  = make_row(KIND_HIT, make_addr(3, 63, 5), 1, ACC_READ, 0, 0, 0);
    directed_rows[10] = make_row(KIND_FILL, '1, 0, ACC_WRITE, 1, 0, 0);
    directed_rows[11] = make_row(KIND_FILL, make_addr('0, 63, 0), 0, ACC_READ, 1, 1, 0);
    directed_rows[12] = make_row(KIND_FILL, make_addr(1, 63, 4), 0, ACC_WRITE, 0, 0, 0);
    directed_rows[13] = make_row(KIND_FILL, make_addr(2, 63, 8), 0, ACC_PREFETCH, 0, 0, 0);
    directed_rows[14] = make_row(KIND_FILL, 48'h5555_5555_5555, 0, ACC_READ, 0, 0, 0);
    directed_rows[15] = make_row(KIND_FILL, 48'hAAAA_AAAA_AAAA, 0, ACC_WRITE, 0, 0, 0);
    directed_rows[16] = make_row(KIND_HIT, 48'hAAAA_AAAA_AAAA, 1, ACC_READ, 0, 0, 0);
    directed_rows[17] = make_row(KIND_FILL, '0, 0, ACC_OTHER, 0, 0, 0);

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // The clearing pass after reset still takes register writes.
    write_reg(REG_WAYS_IN_USE, 2);
    write_reg(REG_WRITE_BACK_MODE, 1);
    write_reg(REG_PROTECT_DIST, 255);
    for (int i = 0; i < ROWS; i++)
      push_access(directed_rows[i].kind, directed_rows[i].addr, directed_rows[i].way,
                  directed_rows[i].acc, directed_rows[i].typed, directed_rows[i].res);

    // Random phases across the register space; the long hold-off comes in the
    // over-range phase and the last phase runs with no idling at all.
    run_phase(16, 1, 16, 0, 0);
    run_phase(4, 0, 1, 10, 0);
    run_phase(1, 1, 255, 20, 0);
    run_phase(31, 1, 3, 30, 1);
    run_phase(0, 0, 0, 40, 0);
    run_phase(7, 1, 40, 50, 0);
    drain();
    steady = 1;
    run_phase(16, 1, 8, 62, 0);
    drain();

    if (pending_victims.size() != 0) begin
      errors++;
      $display("%0t: %0d victims still expected at the end, expected 0",
               $time, pending_victims.size());
    end
    $display("Covered %0d fills, %0d of them evicting a valid line and %0d writing back,",
             fills_seen, valid_evictions, writebacks_seen);
    $display("and %0d hits applied plus %0d ignored, across eight register settings.",
             hits_applied, hits_ignored);
    if (errors == 0) begin
      $display("tb_protecting_distance_replacement_top: clean");
    end else begin
      $display("tb_protecting_distance_replacement_top: errors");
    end
    $finish;
  end

  // Watchdog on the cycle count.
  initial begin
    while (cycle_count < LIMIT) @(posedge clk);
    $display("Timed out after %0d cycles.", cycle_count);
    $display("tb_protecting_distance_replacement_top: errors");
    $finish;
  end

endmodule
